### rtl/core/cmk_pkg.sv
`default_nettype none

package cmk_pkg;

    // Default number of fraction bits carried by the distance square root.
    localparam int SQRT_FRAC_DEFAULT = 8;

    localparam int CHANNELS  = 3;
    localparam int QUOT_BITS = 8;

    localparam logic [7:0]  FULL_SCALE   = 8'd255;
    localparam logic [7:0]  HALF_SCALE   = 8'd127;
    localparam logic [7:0]  DESPILL_LEAD = 8'd24;
    localparam logic [6:0]  PERCENT_FULL = 7'd100;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 25600.
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_RED         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_GREEN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BLUE        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SOFTNESS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNBLEND_ENABLE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DESPILL_ENABLE  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DESPILL_PERCENT = 3'd7;

    localparam logic [1:0] CLASS_KEYED   = 2'd0;
    localparam logic [1:0] CLASS_PARTIAL = 2'd1;
    localparam logic [1:0] CLASS_OPAQUE  = 2'd2;

    typedef logic [7:0] chan_t;
    typedef logic [CHANNELS-1:0][7:0] rgb_t;

    // Exact floor(x / 255) for the products of two 8-bit values plus rounding.
    function automatic chan_t div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

### rtl/core/color_key_matte.sv
`default_nettype none
// Colour key matte with unblend and despill, one pixel per beat.
//
// Input beats (s_valid/s_ready) carry an RGBA pixel; every input beat yields
// exactly one output beat (m_valid/m_ready) with the keyed colour, combined
// alpha, the coverage class and two status flags. Configuration registers
// are written through cfg_valid/cfg_ready/cfg_index/cfg_data, which is always
// ready; write them only while no pixel is in flight.
//
// The datapath is a single pipeline of SQRT_FRACTION_BITS + 34 register
// stages. One pixel is taken every cycle unless the receiver stalls; the
// depth is set by the bit-per-stage square root and the two bit-per-stage
// dividers.
//
// When the receiver stalls, the whole pipeline holds and s_ready falls in the
// same cycle, so nothing is dropped or repeated. Reset (aresetn low at a
// rising edge) empties the pipeline and returns every configuration register
// to its documented default.
module color_key_matte
    import cmk_pkg::*;
#(
    parameter int SQRT_FRACTION_BITS = SQRT_FRAC_DEFAULT
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire  [7:0]             s_in_red,
    input  wire  [7:0]             s_in_green,
    input  wire  [7:0]             s_in_blue,
    input  wire  [7:0]             s_in_alpha,

    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [7:0]             m_out_red,
    output logic [7:0]             m_out_green,
    output logic [7:0]             m_out_blue,
    output logic [7:0]             m_out_alpha,
    output logic [1:0]             m_key_class,
    output logic                   m_unblend_changed,
    output logic                   m_despill_applied,

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire  [CFG_INDEX_W-1:0] cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_data
);

    localparam int F      = SQRT_FRACTION_BITS;
    // The distance is below 442, so its root needs 9 integer bits.
    localparam int ROOT_W = 9 + F;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    // Ramp dividend 2 * 255 * diff + ramp_den / 2.
    localparam int NUM_W  = ROOT_W + 10;
    localparam int UB_W   = 17;

    typedef struct packed {
        rgb_t  rgb;
        chan_t alpha;
        logic  keyed;
        logic  opaque;
    } ctx_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } sqrt_t;

    // One result bit of the integer square root.
    function automatic sqrt_t sqrt_step(input sqrt_t cur);
        sqrt_t            nx;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        rem_sh = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
        trial  = {1'b0, cur.root, 2'b01};
        nx.rad = {cur.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            nx.rem  = rem_sh - trial;
            nx.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nx.rem  = rem_sh;
            nx.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nx;
    endfunction

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [7:0] key_red_reg, key_green_reg, key_blue_reg;
    logic [8:0] tolerance_reg, softness_reg;
    logic       unblend_enable_reg, despill_enable_reg;
    logic [6:0] despill_percent_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_red_reg         <= 8'd255;
            key_green_reg       <= 8'd255;
            key_blue_reg        <= 8'd255;
            tolerance_reg       <= 9'd12;
            softness_reg        <= 9'd48;
            unblend_enable_reg  <= 1'b1;
            despill_enable_reg  <= 1'b0;
            despill_percent_reg <= 7'd100;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_RED:         key_red_reg         <= cfg_data[7:0];
                REG_KEY_GREEN:       key_green_reg       <= cfg_data[7:0];
                REG_KEY_BLUE:        key_blue_reg        <= cfg_data[7:0];
                REG_TOLERANCE:       tolerance_reg       <= cfg_data;
                REG_SOFTNESS:        softness_reg        <= cfg_data;
                REG_UNBLEND_ENABLE:  unblend_enable_reg  <= cfg_data[0];
                REG_DESPILL_ENABLE:  despill_enable_reg  <= cfg_data[0];
                REG_DESPILL_PERCENT: despill_percent_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Values derived from the configuration alone. The user must keep them stable
    // while pixels are in flight (the block does not enforce it), so every stage may read them directly.
    rgb_t        key_rgb;
    logic [17:0] tol_sq;
    logic [9:0]  tol_outer;
    logic [19:0] tol_outer_sq;
    logic [1:0]  spill_idx;
    logic [1:0]  second_idx;
    logic        despill_on;
    logic [6:0]  keep_pct;

    assign key_rgb      = {key_blue_reg, key_green_reg, key_red_reg};
    assign tol_sq       = {9'd0, tolerance_reg} * {9'd0, tolerance_reg};
    assign tol_outer    = {1'b0, tolerance_reg} + {1'b0, softness_reg};
    assign tol_outer_sq = {10'd0, tol_outer} * {10'd0, tol_outer};

    always_comb begin
        // Dominant key channel is the first largest; the runner-up is the
        // first largest of the remaining two.
        spill_idx = 2'd0;
        if (key_rgb[1] > key_rgb[0]) begin
            spill_idx = 2'd1;
        end
        if (key_rgb[2] > key_rgb[spill_idx]) begin
            spill_idx = 2'd2;
        end
        case (spill_idx)
            2'd0:    second_idx = (key_rgb[2] > key_rgb[1]) ? 2'd2 : 2'd1;
            2'd1:    second_idx = (key_rgb[2] > key_rgb[0]) ? 2'd2 : 2'd0;
            2'd2:    second_idx = (key_rgb[1] > key_rgb[0]) ? 2'd1 : 2'd0;
            default: second_idx = 2'd0;
        endcase
        despill_on = despill_enable_reg && (despill_percent_reg != 7'd0)
                     && ((key_rgb[spill_idx] - key_rgb[second_idx]) >= DESPILL_LEAD);
        keep_pct   = (despill_percent_reg > PERCENT_FULL) ? 7'd0
                     : PERCENT_FULL - despill_percent_reg;
    end

    //------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the output
    // register holds a beat that the receiver has not yet taken.
    //------------------------------------------------------------------
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Stage 1: squared distance to the key colour.
    logic        v1_reg;
    ctx_t        ctx1_reg, ctx1_next;
    logic [17:0] d2_1_reg, d2_1_next;

    always_comb begin
        logic [7:0] ad;
        d2_1_next        = '0;
        ctx1_next.rgb    = {s_in_blue, s_in_green, s_in_red};
        ctx1_next.alpha  = s_in_alpha;
        ctx1_next.keyed  = 1'b0;
        ctx1_next.opaque = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            ad = (ctx1_next.rgb[c] > key_rgb[c]) ? ctx1_next.rgb[c] - key_rgb[c]
                                                 : key_rgb[c] - ctx1_next.rgb[c];
            d2_1_next = d2_1_next + 18'({8'd0, ad} * {8'd0, ad});
        end
    end

    // Stage 2: region tests against the tolerance bounds.
    logic        v2_reg;
    ctx_t        ctx2_reg, ctx2_next;
    logic [17:0] d2_2_reg;

    always_comb begin
        ctx2_next        = ctx1_reg;
        ctx2_next.keyed  = d2_1_reg <= tol_sq;
        ctx2_next.opaque = (softness_reg == 9'd0) || ({2'b00, d2_1_reg} >= tol_outer_sq);
    end

    // Square root stages, one result bit each.
    logic  sq_v_reg   [ROOT_W];
    ctx_t  sq_ctx_reg [ROOT_W];
    sqrt_t sq_reg     [ROOT_W];
    sqrt_t sq_next    [ROOT_W];
    sqrt_t sq_init;

    always_comb begin
        sq_init.rem  = '0;
        sq_init.root = '0;
        sq_init.rad  = {d2_2_reg, {(2 * F){1'b0}}};
        sq_next[0]   = sqrt_step(sq_init);
        for (int j = 1; j < ROOT_W; j++) begin
            sq_next[j] = sqrt_step(sq_reg[j-1]);
        end
    end

    // Ramp numerator: dividend 2 * 255 * (s - base) + ramp_den / 2.
    logic               rn_v_reg;
    ctx_t               rn_ctx_reg;
    logic [NUM_W-1:0]   rn_num_reg, rn_num_next;
    logic [ROOT_W:0]    ramp_den;

    assign ramp_den = {softness_reg, {(F + 1){1'b0}}};

    always_comb begin
        logic [ROOT_W-1:0]   s_val;
        logic [ROOT_W-1:0]   base;
        logic [ROOT_W-1:0]   diff;
        logic [ROOT_W+7:0]   scaled;
        s_val       = sq_reg[ROOT_W-1].root;
        base        = {tolerance_reg, {F{1'b0}}};
        diff        = (s_val > base) ? s_val - base : '0;
        scaled      = {diff, 8'd0} - {8'd0, diff};
        rn_num_next = {1'b0, scaled, 1'b0}
                      + {{(NUM_W - ROOT_W){1'b0}}, softness_reg, {F{1'b0}}};
    end

    // Ramp divider, one quotient bit per stage, most significant first.
    logic             dv_v_reg   [QUOT_BITS];
    ctx_t             dv_ctx_reg [QUOT_BITS];
    logic [NUM_W-1:0] dv_rem_reg [QUOT_BITS];
    logic [NUM_W-1:0] dv_rem_next[QUOT_BITS];
    logic [7:0]       dv_q_reg   [QUOT_BITS];
    logic [7:0]       dv_q_next  [QUOT_BITS];

    always_comb begin
        logic [NUM_W-1:0] rem_in;
        logic [7:0]       q_in;
        logic [NUM_W-1:0] dsh;
        for (int j = 0; j < QUOT_BITS; j++) begin
            rem_in = (j == 0) ? rn_num_reg : dv_rem_reg[(j > 0) ? j - 1 : 0];
            q_in   = (j == 0) ? 8'd0 : dv_q_reg[(j > 0) ? j - 1 : 0];
            dsh    = {{(NUM_W - ROOT_W - 1){1'b0}}, ramp_den} << (QUOT_BITS - 1 - j);
            if (rem_in >= dsh) begin
                dv_rem_next[j] = rem_in - dsh;
                dv_q_next[j]   = {q_in[6:0], 1'b1};
            end else begin
                dv_rem_next[j] = rem_in;
                dv_q_next[j]   = {q_in[6:0], 1'b0};
            end
        end
    end

    // Key coverage.
    logic  cv_v_reg;
    rgb_t  cv_rgb_reg;
    chan_t cv_alpha_reg;
    chan_t cv_k_reg, cv_k_next;

    always_comb begin
        if (dv_ctx_reg[QUOT_BITS-1].keyed) begin
            cv_k_next = 8'd0;
        end else if (dv_ctx_reg[QUOT_BITS-1].opaque) begin
            cv_k_next = FULL_SCALE;
        end else begin
            cv_k_next = dv_q_reg[QUOT_BITS-1];
        end
    end

    // Products for alpha scaling and the unblend numerators.
    logic            mu_v_reg;
    rgb_t            mu_rgb_reg;
    chan_t           mu_alpha_reg;
    chan_t           mu_k_reg;
    logic            mu_apply_reg, mu_apply_next;
    logic [15:0]     mu_prod_reg, mu_prod_next;
    logic [2:0]      mu_neg_reg, mu_neg_next;
    logic [UB_W-1:0] mu_num_reg [CHANNELS];
    logic [UB_W-1:0] mu_num_next[CHANNELS];

    always_comb begin
        logic [15:0] p_src;
        logic [15:0] p_key;
        logic [15:0] p_diff;
        mu_prod_next  = {8'd0, cv_k_reg} * {8'd0, cv_alpha_reg};
        mu_apply_next = unblend_enable_reg && (cv_k_reg != 8'd0) && (cv_k_reg != FULL_SCALE);
        for (int c = 0; c < CHANNELS; c++) begin
            p_src          = {cv_rgb_reg[c], 8'd0} - {8'd0, cv_rgb_reg[c]};
            p_key          = {8'd0, FULL_SCALE - cv_k_reg} * {8'd0, key_rgb[c]};
            p_diff         = p_src - p_key;
            mu_neg_next[c] = p_src < p_key;
            mu_num_next[c] = {p_diff, 1'b0} + {9'd0, cv_k_reg};
        end
    end

    // Unblend dividers, three lanes, one quotient bit per stage. The first
    // stage also finishes the alpha scaling and flags saturation.
    logic            ub_v_reg     [QUOT_BITS];
    rgb_t            ub_rgb_reg   [QUOT_BITS];
    chan_t           ub_k_reg     [QUOT_BITS];
    chan_t           ub_a_reg     [QUOT_BITS];
    logic            ub_apply_reg [QUOT_BITS];
    logic [2:0]      ub_neg_reg   [QUOT_BITS];
    logic [2:0]      ub_ovf_reg   [QUOT_BITS];
    logic [2:0]      ub_ovf_next  [QUOT_BITS];
    logic [UB_W-1:0] ub_rem_reg   [QUOT_BITS][CHANNELS];
    logic [UB_W-1:0] ub_rem_next  [QUOT_BITS][CHANNELS];
    logic [7:0]      ub_q_reg     [QUOT_BITS][CHANNELS];
    logic [7:0]      ub_q_next    [QUOT_BITS][CHANNELS];
    chan_t           ub_a_first;

    always_comb begin
        logic [UB_W-1:0] rem_in;
        logic [7:0]      q_in;
        logic [UB_W-1:0] dsh;
        chan_t           k_in;
        ub_a_first = (mu_alpha_reg == FULL_SCALE) ? mu_k_reg
                     : div255(mu_prod_reg + {8'd0, HALF_SCALE});
        for (int j = 0; j < QUOT_BITS; j++) begin
            k_in = (j == 0) ? mu_k_reg : ub_k_reg[(j > 0) ? j - 1 : 0];
            for (int c = 0; c < CHANNELS; c++) begin
                rem_in = (j == 0) ? mu_num_reg[c] : ub_rem_reg[(j > 0) ? j - 1 : 0][c];
                q_in   = (j == 0) ? 8'd0 : ub_q_reg[(j > 0) ? j - 1 : 0][c];
                dsh    = {8'd0, k_in, 1'b0} << (QUOT_BITS - 1 - j);
                if (rem_in >= dsh) begin
                    ub_rem_next[j][c] = rem_in - dsh;
                    ub_q_next[j][c]   = {q_in[6:0], 1'b1};
                end else begin
                    ub_rem_next[j][c] = rem_in;
                    ub_q_next[j][c]   = {q_in[6:0], 1'b0};
                end
            end
            if (j == 0) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    ub_ovf_next[j][c] = mu_num_reg[c] >= {mu_k_reg, 1'b0, 8'd0};
                end
            end else begin
                ub_ovf_next[j] = ub_ovf_reg[(j > 0) ? j - 1 : 0];
            end
        end
    end

    // Unblend result and coverage class.
    logic       ur_v_reg;
    rgb_t       ur_rgb_reg, ur_rgb_next;
    chan_t      ur_a_reg;
    logic [1:0] ur_cls_reg, ur_cls_next;
    logic       ur_changed_reg, ur_changed_next;

    always_comb begin
        localparam int L = QUOT_BITS - 1;
        chan_t nv;
        ur_changed_next = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (!ub_apply_reg[L]) begin
                nv = ub_rgb_reg[L][c];
            end else if (ub_neg_reg[L][c]) begin
                nv = 8'd0;
            end else if (ub_ovf_reg[L][c]) begin
                nv = FULL_SCALE;
            end else begin
                nv = ub_q_reg[L][c];
            end
            if (ub_apply_reg[L] && (nv != ub_rgb_reg[L][c])) begin
                ur_changed_next = 1'b1;
            end
            ur_rgb_next[c] = nv;
        end
        if (ub_k_reg[L] == 8'd0) begin
            ur_cls_next = CLASS_KEYED;
        end else if (ub_k_reg[L] == FULL_SCALE) begin
            ur_cls_next = CLASS_OPAQUE;
        end else begin
            ur_cls_next = CLASS_PARTIAL;
        end
    end

    // Despill: excess of the dominant channel times the kept percentage.
    logic        ds_v_reg;
    rgb_t        ds_rgb_reg;
    chan_t       ds_a_reg;
    logic [1:0]  ds_cls_reg;
    logic        ds_changed_reg;
    chan_t       ds_limit_reg, ds_limit_next;
    logic        ds_apply_reg, ds_apply_next;
    logic [14:0] ds_prod_reg, ds_prod_next;

    always_comb begin
        chan_t lead;
        chan_t excess;
        case (spill_idx)
            2'd0: ds_limit_next = (ur_rgb_reg[1] > ur_rgb_reg[2]) ? ur_rgb_reg[1] : ur_rgb_reg[2];
            2'd1: ds_limit_next = (ur_rgb_reg[0] > ur_rgb_reg[2]) ? ur_rgb_reg[0] : ur_rgb_reg[2];
            2'd2: ds_limit_next = (ur_rgb_reg[0] > ur_rgb_reg[1]) ? ur_rgb_reg[0] : ur_rgb_reg[1];
            default: ds_limit_next = 8'd0;
        endcase
        lead          = ur_rgb_reg[spill_idx];
        ds_apply_next = despill_on && (lead > ds_limit_next);
        excess        = lead - ds_limit_next;
        ds_prod_next  = {7'd0, excess} * {8'd0, keep_pct};
    end

    // Division by 100 through the reciprocal.
    logic        sc_v_reg;
    rgb_t        sc_rgb_reg;
    chan_t       sc_a_reg;
    logic [1:0]  sc_cls_reg;
    logic        sc_changed_reg;
    chan_t       sc_limit_reg;
    logic        sc_apply_reg;
    logic [27:0] sc_scaled_reg, sc_scaled_next;

    assign sc_scaled_next = {13'd0, ds_prod_reg} * {15'd0, RECIP_100};

    // Output register.
    rgb_t       out_rgb_reg, out_rgb_next;
    chan_t      out_alpha_reg, out_alpha_next;
    logic [1:0] out_cls_reg;
    logic       out_changed_reg, out_changed_next;
    logic       out_spill_reg, out_spill_next;
    logic       m_valid_reg;

    always_comb begin
        chan_t quo;
        quo = sc_scaled_reg[RECIP_100_SHIFT +: 8];
        out_rgb_next = sc_rgb_reg;
        if (sc_apply_reg) begin
            out_rgb_next[spill_idx] = sc_limit_reg + quo;
        end
        out_alpha_next   = sc_a_reg;
        out_changed_next = sc_changed_reg;
        out_spill_next   = sc_apply_reg;
        // A fully transparent result is black with both flags clear.
        if (sc_a_reg == 8'd0) begin
            out_rgb_next     = '0;
            out_changed_next = 1'b0;
            out_spill_next   = 1'b0;
        end
    end

    //------------------------------------------------------------------
    // Valid bits
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            rn_v_reg    <= 1'b0;
            cv_v_reg    <= 1'b0;
            mu_v_reg    <= 1'b0;
            ur_v_reg    <= 1'b0;
            ds_v_reg    <= 1'b0;
            sc_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < ROOT_W; j++) begin
                sq_v_reg[j] <= 1'b0;
            end
            for (int j = 0; j < QUOT_BITS; j++) begin
                dv_v_reg[j] <= 1'b0;
                ub_v_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            sq_v_reg[0] <= v2_reg;
            for (int j = 1; j < ROOT_W; j++) begin
                sq_v_reg[j] <= sq_v_reg[j-1];
            end
            rn_v_reg    <= sq_v_reg[ROOT_W-1];
            dv_v_reg[0] <= rn_v_reg;
            ub_v_reg[0] <= mu_v_reg;
            for (int j = 1; j < QUOT_BITS; j++) begin
                dv_v_reg[j] <= dv_v_reg[j-1];
                ub_v_reg[j] <= ub_v_reg[j-1];
            end
            cv_v_reg    <= dv_v_reg[QUOT_BITS-1];
            mu_v_reg    <= cv_v_reg;
            ur_v_reg    <= ub_v_reg[QUOT_BITS-1];
            ds_v_reg    <= ur_v_reg;
            sc_v_reg    <= ds_v_reg;
            m_valid_reg <= sc_v_reg;
        end
    end

    //------------------------------------------------------------------
    // Payload registers
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctx1_reg <= ctx1_next;
            d2_1_reg <= d2_1_next;
            ctx2_reg <= ctx2_next;
            d2_2_reg <= d2_1_reg;

            sq_ctx_reg[0] <= ctx2_reg;
            for (int j = 1; j < ROOT_W; j++) begin
                sq_ctx_reg[j] <= sq_ctx_reg[j-1];
            end
            for (int j = 0; j < ROOT_W; j++) begin
                sq_reg[j] <= sq_next[j];
            end

            rn_ctx_reg <= sq_ctx_reg[ROOT_W-1];
            rn_num_reg <= rn_num_next;

            dv_ctx_reg[0] <= rn_ctx_reg;
            for (int j = 1; j < QUOT_BITS; j++) begin
                dv_ctx_reg[j] <= dv_ctx_reg[j-1];
            end
            for (int j = 0; j < QUOT_BITS; j++) begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
            end

            cv_rgb_reg   <= dv_ctx_reg[QUOT_BITS-1].rgb;
            cv_alpha_reg <= dv_ctx_reg[QUOT_BITS-1].alpha;
            cv_k_reg     <= cv_k_next;

            mu_rgb_reg   <= cv_rgb_reg;
            mu_alpha_reg <= cv_alpha_reg;
            mu_k_reg     <= cv_k_reg;
            mu_apply_reg <= mu_apply_next;
            mu_prod_reg  <= mu_prod_next;
            mu_neg_reg   <= mu_neg_next;
            mu_num_reg   <= mu_num_next;

            ub_rgb_reg[0]   <= mu_rgb_reg;
            ub_k_reg[0]     <= mu_k_reg;
            ub_a_reg[0]     <= ub_a_first;
            ub_apply_reg[0] <= mu_apply_reg;
            ub_neg_reg[0]   <= mu_neg_reg;
            for (int j = 1; j < QUOT_BITS; j++) begin
                ub_rgb_reg[j]   <= ub_rgb_reg[j-1];
                ub_k_reg[j]     <= ub_k_reg[j-1];
                ub_a_reg[j]     <= ub_a_reg[j-1];
                ub_apply_reg[j] <= ub_apply_reg[j-1];
                ub_neg_reg[j]   <= ub_neg_reg[j-1];
            end
            for (int j = 0; j < QUOT_BITS; j++) begin
                ub_ovf_reg[j] <= ub_ovf_next[j];
                ub_rem_reg[j] <= ub_rem_next[j];
                ub_q_reg[j]   <= ub_q_next[j];
            end

            ur_rgb_reg     <= ur_rgb_next;
            ur_a_reg       <= ub_a_reg[QUOT_BITS-1];
            ur_cls_reg     <= ur_cls_next;
            ur_changed_reg <= ur_changed_next;

            ds_rgb_reg     <= ur_rgb_reg;
            ds_a_reg       <= ur_a_reg;
            ds_cls_reg     <= ur_cls_reg;
            ds_changed_reg <= ur_changed_reg;
            ds_limit_reg   <= ds_limit_next;
            ds_apply_reg   <= ds_apply_next;
            ds_prod_reg    <= ds_prod_next;

            sc_rgb_reg     <= ds_rgb_reg;
            sc_a_reg       <= ds_a_reg;
            sc_cls_reg     <= ds_cls_reg;
            sc_changed_reg <= ds_changed_reg;
            sc_limit_reg   <= ds_limit_reg;
            sc_apply_reg   <= ds_apply_reg;
            sc_scaled_reg  <= sc_scaled_next;

            out_rgb_reg     <= out_rgb_next;
            out_alpha_reg   <= out_alpha_next;
            out_cls_reg     <= sc_cls_reg;
            out_changed_reg <= out_changed_next;
            out_spill_reg   <= out_spill_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_red         = out_rgb_reg[0];
    assign m_out_green       = out_rgb_reg[1];
    assign m_out_blue        = out_rgb_reg[2];
    assign m_out_alpha       = out_alpha_reg;
    assign m_key_class       = out_cls_reg;
    assign m_unblend_changed = out_changed_reg;
    assign m_despill_applied = out_spill_reg;

`ifndef SYNTHESIS
    // A fully keyed pixel can never keep any alpha.
    a_keyed_transparent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_key_class == CLASS_KEYED) |-> (m_out_alpha == 8'd0))
        else $error("keyed pixel left with nonzero alpha");

    // Transparent results are black with both flags clear.
    a_zero_alpha_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_alpha == 8'd0) |->
            (m_out_red == 8'd0) && (m_out_green == 8'd0) && (m_out_blue == 8'd0)
            && !m_unblend_changed && !m_despill_applied)
        else $error("transparent pixel not cleared");

    // Unblending only ever touches partially covered pixels.
    a_unblend_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unblend_changed |-> (m_key_class == CLASS_PARTIAL))
        else $error("unblend flagged outside the coverage ramp");

    // Despill can only fire while it is enabled.
    a_despill_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_despill_applied |-> despill_enable_reg)
        else $error("despill applied while disabled");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the colour key matte.
module testbench;
    import cmk_pkg::*;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] cls;
        logic       changed;
        logic       spilled;
    } matte_pix_t;

    // One row of the directed table. Where known is set, the expected beat is typed in.
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        bit         known;
        matte_pix_t want;
    } directed_row_t;

    // A full register setting for one phase of the run.
    typedef struct {
        logic [7:0] key_r;
        logic [7:0] key_g;
        logic [7:0] key_b;
        logic [8:0] tol;
        logic [8:0] ramp_w;
        logic       unblend;
        logic       despill;
        logic [6:0] pct;
    } key_setting_t;

    localparam int NUM_PHASES     = 8;
    localparam int PIXELS_PER_PHASE = 240;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 60;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_red, s_in_green, s_in_blue, s_in_alpha;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_red, m_out_green, m_out_blue, m_out_alpha;
    logic [1:0] m_key_class;
    logic       m_unblend_changed;
    logic       m_despill_applied;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the key registers, updated on every accepted write beat.
    logic [7:0] sh_key [3];
    logic [8:0] sh_tol, sh_soft;
    logic       sh_unblend, sh_despill;
    logic [6:0] sh_pct;

    matte_pix_t pending_pixels[$];
    int         mismatches;
    int         pixels_in;
    int         pixels_out;
    int         idle_cycles;
    bit         quiet_mode;
    bit         hold_off_done;

    color_key_matte dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_red(s_in_red), .s_in_green(s_in_green),
        .s_in_blue(s_in_blue), .s_in_alpha(s_in_alpha),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green),
        .m_out_blue(m_out_blue), .m_out_alpha(m_out_alpha),
        .m_key_class(m_key_class), .m_unblend_changed(m_unblend_changed),
        .m_despill_applied(m_despill_applied),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Floor of the square root, found one result bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned trial;
        int b;
        res = 0;
        for (b = 20; b >= 0; b--) begin
            trial = res | (longint'(1) << b);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    // Works out the result beat for one pixel under the shadow registers.
    function automatic matte_pix_t matte_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] src_a);
        int ch[3];
        int kc[3];
        int d2, t0, ramp_w, t1, cov, a, i, n, q, dom, sec, lim, pct, keep;
        longint unsigned s, base, den, num, qq;
        bit changed, spilled;
        matte_pix_t o;
        ch[0] = r; ch[1] = g; ch[2] = b;
        for (i = 0; i < 3; i++) kc[i] = sh_key[i];
        t0 = sh_tol;
        ramp_w = sh_soft;
        t1 = t0 + ramp_w;
        d2 = 0;
        for (i = 0; i < 3; i++) d2 += (ch[i] - kc[i]) * (ch[i] - kc[i]);

        // Coverage: keyed inside tolerance, opaque beyond the ramp, linear in between.
        if (d2 <= t0 * t0) begin
            cov = 0;
        end else if (ramp_w == 0 || d2 >= t1 * t1) begin
            cov = 255;
        end else begin
            s = floor_root(longint'(d2) << 16);
            base = longint'(t0) << 8;
            den = longint'(ramp_w) << 8;
            num = (s > base) ? (s - base) * 255 : 0;
            qq = (2 * num + den) / (2 * den);
            cov = (qq > 255) ? 255 : int'(qq);
        end
        a = (src_a < 255) ? (cov * src_a + 127) / 255 : cov;

        o.cls = (cov == 0) ? CLASS_KEYED : ((cov == 255) ? CLASS_OPAQUE : CLASS_PARTIAL);
        if (a == 0) begin
            o.red = 0; o.green = 0; o.blue = 0; o.alpha = 0;
            o.changed = 0; o.spilled = 0;
            return o;
        end

        changed = 0;
        if (sh_unblend && cov > 0 && cov < 255) begin
            for (i = 0; i < 3; i++) begin
                n = 255 * ch[i] - (255 - cov) * kc[i];
                q = (n < 0) ? 0 : (2 * n + cov) / (2 * cov);
                if (q > 255) q = 255;
                if (q != ch[i]) changed = 1;
                ch[i] = q;
            end
        end

        // Despill acts on the strongest key channel only when it clearly leads.
        spilled = 0;
        if (sh_despill && sh_pct != 0) begin
            dom = 0;
            for (i = 1; i < 3; i++) if (kc[i] > kc[dom]) dom = i;
            sec = -1;
            for (i = 0; i < 3; i++)
                if (i != dom && (sec < 0 || kc[i] > kc[sec])) sec = i;
            if (kc[dom] - kc[sec] >= DESPILL_LEAD) begin
                lim = -1;
                for (i = 0; i < 3; i++) if (i != dom && ch[i] > lim) lim = ch[i];
                pct = (sh_pct > PERCENT_FULL) ? 100 : sh_pct;
                keep = 100 - pct;
                if (ch[dom] > lim) begin
                    ch[dom] = lim + ((ch[dom] - lim) * keep) / 100;
                    spilled = 1;
                end
            end
        end

        o.red = 8'(ch[0]); o.green = 8'(ch[1]); o.blue = 8'(ch[2]); o.alpha = 8'(a);
        o.changed = changed;
        o.spilled = spilled;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    directed_row_t directed[] = '{
        // Exactly on the default white key: fully keyed, so everything is black.
        '{8'd255, 8'd255, 8'd255, 8'd255, 1, '{8'd0, 8'd0, 8'd0, 8'd0, CLASS_KEYED, 1'b0, 1'b0}},
        // Black is far from white: opaque and passed through untouched.
        '{8'd0, 8'd0, 8'd0, 8'd255, 1, '{8'd0, 8'd0, 8'd0, 8'd255, CLASS_OPAQUE, 1'b0, 1'b0}},
        // Zero source alpha blanks the pixel but still reports the class.
        '{8'd0, 8'd0, 8'd0, 8'd0, 1, '{8'd0, 8'd0, 8'd0, 8'd0, CLASS_OPAQUE, 1'b0, 1'b0}},
        '{8'd255, 8'd255, 8'd255, 8'd0, 1, '{8'd0, 8'd0, 8'd0, 8'd0, CLASS_KEYED, 1'b0, 1'b0}},
        // Opaque with half alpha: alpha is simply scaled.
        '{8'd10, 8'd200, 8'd30, 8'd128, 1,
          '{8'd10, 8'd200, 8'd30, 8'd128, CLASS_OPAQUE, 1'b0, 1'b0}},
        // The remaining rows sit on or across the ramp and go through the predictor.
        '{8'd255, 8'd255, 8'd243, 8'd255, 0, '0},
        '{8'd255, 8'd255, 8'd242, 8'd255, 0, '0},
        '{8'd255, 8'd255, 8'd225, 8'd255, 0, '0},
        '{8'd255, 8'd255, 8'd196, 8'd255, 0, '0},
        '{8'd255, 8'd255, 8'd195, 8'd255, 0, '0},
        '{8'd230, 8'd240, 8'd250, 8'd1, 0, '0},
        '{8'd240, 8'd230, 8'd220, 8'd254, 0, '0},
        '{8'd200, 8'd255, 8'd255, 8'd77, 0, '0},
        '{8'd255, 8'd128, 8'd255, 8'd255, 0, '0}
    };

    // Monitor: all sampling happens here, on pre-edge values.
    always @(posedge aclk) begin
        matte_pix_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_RED:         sh_key[0] <= cfg_data[7:0];
                    REG_KEY_GREEN:       sh_key[1] <= cfg_data[7:0];
                    REG_KEY_BLUE:        sh_key[2] <= cfg_data[7:0];
                    REG_TOLERANCE:       sh_tol <= cfg_data;
                    REG_SOFTNESS:        sh_soft <= cfg_data;
                    REG_UNBLEND_ENABLE:  sh_unblend <= cfg_data[0];
                    REG_DESPILL_ENABLE:  sh_despill <= cfg_data[0];
                    REG_DESPILL_PERCENT: sh_pct <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                // The first beats are the directed rows; typed-in rows take their own answer.
                if (pixels_in < directed.size() && directed[pixels_in].known)
                    pending_pixels.push_back(directed[pixels_in].want);
                else
                    pending_pixels.push_back(matte_pixel(s_in_red, s_in_green, s_in_blue,
                                                         s_in_alpha));
                pixels_in++;
            end
            if (m_valid && m_ready) begin
                pixels_out++;
                if (pending_pixels.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 1, 0);
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_out_red !== want.red) report_mismatch("red", m_out_red, want.red);
                    if (m_out_green !== want.green)
                        report_mismatch("green", m_out_green, want.green);
                    if (m_out_blue !== want.blue) report_mismatch("blue", m_out_blue, want.blue);
                    if (m_out_alpha !== want.alpha)
                        report_mismatch("alpha", m_out_alpha, want.alpha);
                    if (m_key_class !== want.cls) report_mismatch("class", m_key_class, want.cls);
                    if (m_unblend_changed !== want.changed)
                        report_mismatch("unblend_changed", m_unblend_changed, want.changed);
                    if (m_despill_applied !== want.spilled)
                        report_mismatch("despill_applied", m_despill_applied, want.spilled);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: too long without any beat on any channel ends the run.
    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off so the pipeline backs up,
    // and a steady ready once the run reaches its quiet last phase.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (quiet_mode) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (!hold_off_done && pixels_out >= 150) begin
                hold_off_done = 1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Offers one pixel and holds it until the beat is taken.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        s_valid <= 1'b1;
        s_in_red <= r; s_in_green <= g; s_in_blue <= b; s_in_alpha <= a;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Between beats the sender sometimes rests and drops valid while it does.
    task automatic sender_gap();
        if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Picks a channel value near the key so that the coverage ramp is exercised.
    function automatic logic [7:0] near_key(input int k, input int reach);
        int v;
        v = k + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 3))
            0: return 8'd255;
            1: return 8'd0;
            2: return 8'($urandom_range(1, 254));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Register settings of the later phases, covering every register and its extremes.
    key_setting_t phase_setting[NUM_PHASES] = '{
        '{8'd255, 8'd255, 8'd255, 9'd12, 9'd48, 1'b1, 1'b0, 7'd100},
        '{8'd0, 8'd255, 8'd0, 9'd20, 9'd60, 1'b1, 1'b1, 7'd100},
        '{8'd0, 8'd0, 8'd255, 9'd0, 9'd0, 1'b0, 1'b1, 7'd127},
        '{8'd255, 8'd0, 8'd0, 9'd511, 9'd511, 1'b1, 1'b1, 7'd50},
        '{8'd40, 8'd180, 8'd60, 9'd30, 9'd100, 1'b1, 1'b1, 7'd0},
        '{8'd128, 8'd128, 8'd128, 9'd5, 9'd1, 1'b1, 1'b1, 7'd100},
        '{8'd0, 8'd0, 8'd0, 9'd0, 9'd511, 1'b1, 1'b0, 7'd37},
        '{8'd0, 8'd200, 8'd40, 9'd16, 9'd40, 1'b1, 1'b1, 7'd75}
    };

    initial begin
        int i, p, reach;
        key_setting_t ks;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_red = '0; s_in_green = '0; s_in_blue = '0; s_in_alpha = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        pixels_in = 0;
        pixels_out = 0;
        idle_cycles = 0;
        quiet_mode = 0;
        hold_off_done = 0;
        sh_key[0] = 8'd255; sh_key[1] = 8'd255; sh_key[2] = 8'd255;
        sh_tol = 9'd12; sh_soft = 9'd48;
        sh_unblend = 1'b1; sh_despill = 1'b0; sh_pct = 7'd100;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows under the reset settings.
        for (i = 0; i < directed.size(); i++) begin
            send_pixel(directed[i].red, directed[i].green, directed[i].blue,
                       directed[i].alpha);
            sender_gap();
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            ks = phase_setting[p];
            if (p > 0) begin
                // Every pixel yields a beat, so an empty queue means an idle pipeline.
                s_valid <= 1'b0;
                while (pending_pixels.size() != 0) @(posedge aclk);
                write_reg(REG_KEY_RED, ks.key_r);
                write_reg(REG_KEY_GREEN, ks.key_g);
                write_reg(REG_KEY_BLUE, ks.key_b);
                write_reg(REG_TOLERANCE, ks.tol);
                write_reg(REG_SOFTNESS, ks.ramp_w);
                write_reg(REG_UNBLEND_ENABLE, ks.unblend);
                write_reg(REG_DESPILL_ENABLE, ks.despill);
                write_reg(REG_DESPILL_PERCENT, ks.pct);
            end
            if (p == NUM_PHASES - 1) quiet_mode = 1;
            reach = ks.tol + ks.ramp_w;
            if (reach < 2) reach = 2;
            if (reach > 200) reach = 200;
            for (i = 0; i < PIXELS_PER_PHASE; i++) begin
                if ($urandom_range(0, 9) < 6)
                    send_pixel(near_key(ks.key_r, reach), near_key(ks.key_g, reach),
                               near_key(ks.key_b, reach), pick_alpha());
                else
                    send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), pick_alpha());
                sender_gap();
            end
        end
        s_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### color_key_matte.f
rtl/core/cmk_pkg.sv
rtl/core/color_key_matte.sv
tb/testbench.sv
